FILE: rtl/core/pcaw_pkg.sv
// ============================================================================
// pcaw_pkg
// Shared types, register indexes and saturation helpers for the clamped
// PID controller with anti-windup.
// ============================================================================
`default_nettype none

package pcaw_pkg;

    localparam int DATA_W   = 32;   // signed Q values
    localparam int GAIN_W   = 31;   // unsigned gains and sample period
    localparam int PROD_W   = 64;   // signed x unsigned product
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 3'd6;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] measurement;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     at_limit;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_MID,
        ST_MUL2,
        ST_SUM1,
        ST_SUM2,
        ST_DONE
    } t_state;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic [DATA_W-1:0] sat34(input logic [DATA_W+1:0] x);
        logic ovf;
        ovf = (x[DATA_W+1:DATA_W-1] != 3'b000) && (x[DATA_W+1:DATA_W-1] != 3'b111);
        if (ovf) begin
            return x[DATA_W+1] ? S32_MIN : S32_MAX;
        end
        return x[DATA_W-1:0];
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [DATA_W-1:0] sat64(input logic [PROD_W-1:0] x);
        logic ovf;
        ovf = (x[PROD_W-1:DATA_W-1] != '0) && (x[PROD_W-1:DATA_W-1] != '1);
        if (ovf) begin
            return x[PROD_W-1] ? S32_MIN : S32_MAX;
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W+1:0] sext34(input logic [DATA_W-1:0] x);
        return {{2{x[DATA_W-1]}}, x};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcaw_mul.sv
// ============================================================================
// pcaw_mul
// Bit-serial shift-add multiplier: signed 32-bit word times unsigned 31-bit
// word, one multiplier bit per cycle, 64-bit signed product.
// ============================================================================
`default_nettype none

module pcaw_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pcaw_pkg::DATA_W-1:0]    i_mcand,
    input  wire logic [pcaw_pkg::GAIN_W-1:0]    i_mplier,
    output logic                                o_done,
    output logic [pcaw_pkg::PROD_W-1:0]         o_product
);
    import pcaw_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);
    localparam int HI_W = PROD_W - GAIN_W + 1;   // partial sum plus growth bit

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_count;
    logic [DATA_W-1:0]   r_mcand;
    logic [PROD_W-1:0]   r_acc;

    logic [HI_W-1:0]     w_sum;
    logic [PROD_W-1:0]   n_acc;

    // add the multiplicand to the upper half when the low bit is set, then
    // shift the whole accumulator right one place
    always_comb begin
        w_sum = {r_acc[PROD_W-1], r_acc[PROD_W-1:GAIN_W]}
              + (r_acc[0] ? {{(HI_W-DATA_W){r_mcand[DATA_W-1]}}, r_mcand} : '0);
        n_acc = {w_sum, r_acc[GAIN_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_LAST;
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_acc   <= {{(PROD_W-GAIN_W){1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

FILE: rtl/core/pcaw_div.sv
// ============================================================================
// pcaw_div
// Bit-serial restoring divider: unsigned dividend by nonzero unsigned 31-bit
// divisor, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pcaw_div #(
    parameter int NUM_W = 48
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [NUM_W-1:0]               i_num,
    input  wire logic [pcaw_pkg::GAIN_W-1:0]    i_den,
    output logic                                o_done,
    output logic [NUM_W-1:0]                    o_quot
);
    import pcaw_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_count;
    logic [GAIN_W-1:0]   r_den;
    logic [GAIN_W-1:0]   r_rem;
    logic [NUM_W-1:0]    r_num;   // dividend shifts out, quotient shifts in

    logic [GAIN_W:0]     w_trial;
    logic [GAIN_W:0]     w_diff;
    logic                w_fits;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fits  = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_LAST;
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[GAIN_W-1:0] : w_trial[GAIN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

FILE: rtl/core/pid_clamped_anti_windup_top.sv
// ============================================================================
// pid_clamped_anti_windup_top
// Positional PID step in signed fixed point with output clamp and
// anti-windup hold of the integral.
// ============================================================================
// An accepted update word runs one 31-step serial multiply pass, then the
// (32 + FRAC_BITS)-step serial divide of the derivative term by dt beside
// the second multiply pass. One word in flight at a time; the next is taken
// the cycle after the result is registered.
// A clear word is taken without leaving the idle state and gives no result.
// Reset: synchronous, restores register defaults and zeroes integral state.
`default_nettype none

module pid_clamped_anti_windup_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire pcaw_pkg::t_in_word                i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pcaw_pkg::t_out_word                    o_out_word,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pcaw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pcaw_pkg::DATA_W-1:0]       i_cfg_data
);
    import pcaw_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;

    // configuration
    logic [GAIN_W-1:0]  r_kp, r_ki, r_kd, r_step_time;
    logic [DATA_W-1:0]  r_target, r_out_low, r_out_high;

    // controller state
    logic [DATA_W-1:0]  r_integral, r_last_err;

    t_state             r_state, n_state;
    logic               r_out_valid;
    t_out_word          r_out_word;

    // datapath
    logic [DATA_W-1:0]  r_err, r_t, r_u, r_inc, r_p, r_d, r_inew;
    logic [DATA_W+1:0]  r_sum;

    logic               w_in_ready, w_mul_start, w_div_start, w_out_load;
    logic               w_in_acc;
    logic [GAIN_W-1:0]  w_dt;
    logic [DATA_W-1:0]  w_diff, w_err_in;
    logic [DATA_W-1:0]  w_mcand0, w_mcand1;
    logic [GAIN_W-1:0]  w_mplier0, w_mplier1;
    logic               w_done0, w_done1, w_mul_done, w_div_done;
    logic signed [PROD_W-1:0] w_prod0, w_prod1;
    logic signed [PROD_W-1:0] w_sh0, w_sh1;
    logic [DATA_W-1:0]  w_abs_u;
    logic [NUM_W-1:0]   w_quot;
    logic               w_q_big;
    logic [DATA_W-1:0]  w_d_sat;
    logic signed [DATA_W+1:0] w_sum_s, w_hi_ext, w_lo_ext;
    logic [DATA_W-1:0]  w_drive;
    logic               w_lim;

    assign w_in_acc = i_in_valid && w_in_ready;
    assign w_dt     = (r_step_time == '0) ? GAIN_W'(1) : r_step_time;
    assign w_err_in = sat34(sext34(r_target) - sext34(i_in_word.measurement));
    assign w_diff   = sat34(sext34(r_err) - sext34(r_last_err));

    // first pass: ki*err and kd*diff; second pass: t*dt and kp*err
    always_comb begin
        if (r_state == ST_PREP) begin
            w_mcand0  = r_err;
            w_mplier0 = r_ki;
            w_mcand1  = w_diff;
            w_mplier1 = r_kd;
        end else begin
            w_mcand0  = r_t;
            w_mplier0 = w_dt;
            w_mcand1  = r_err;
            w_mplier1 = r_kp;
        end
    end

    pcaw_mul u_mul0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mcand0),
        .i_mplier  (w_mplier0),
        .o_done    (w_done0),
        .o_product (w_prod0)
    );

    pcaw_mul u_mul1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mcand1),
        .i_mplier  (w_mplier1),
        .o_done    (w_done1),
        .o_product (w_prod1)
    );

    assign w_mul_done = w_done0 && w_done1;
    assign w_sh0      = w_prod0 >>> FRAC_BITS;
    assign w_sh1      = w_prod1 >>> FRAC_BITS;

    // derivative: |u| * 2^F / dt, sign restored afterwards (truncates to zero)
    assign w_abs_u = r_u[DATA_W-1] ? (~r_u + 1'b1) : r_u;

    pcaw_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_abs_u, {FRAC_BITS{1'b0}}}),
        .i_den   (w_dt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_q_big = |w_quot[NUM_W-1:DATA_W];
        if (!r_u[DATA_W-1]) begin
            w_d_sat = (w_q_big || w_quot[DATA_W-1]) ? S32_MAX : w_quot[DATA_W-1:0];
        end else if (w_q_big || (w_quot[DATA_W-1] && |w_quot[DATA_W-2:0])) begin
            w_d_sat = S32_MIN;
        end else begin
            w_d_sat = ~w_quot[DATA_W-1:0] + 1'b1;
        end
    end

    // clamp: upper bound checked first; crossed bounds go high above it, else low
    always_comb begin
        w_sum_s  = r_sum;
        w_hi_ext = sext34(r_out_high);
        w_lo_ext = sext34(r_out_low);
        if (w_sum_s > w_hi_ext) begin
            w_drive = r_out_high;
        end else if (w_sum_s < w_lo_ext) begin
            w_drive = r_out_low;
        end else begin
            w_drive = r_sum[DATA_W-1:0];
        end
        w_lim = (w_drive == r_out_high) || (w_drive == r_out_low);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid && !i_in_word.mode) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                w_mul_start = 1'b1;
                n_state     = ST_MUL1;
            end
            ST_MUL1: begin
                if (w_mul_done) begin
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                w_mul_start = 1'b1;
                w_div_start = 1'b1;
                n_state     = ST_MUL2;
            end
            ST_MUL2: begin
                // divide always outlasts the multiply
                if (w_div_done) begin
                    n_state = ST_SUM1;
                end
            end
            ST_SUM1: begin
                n_state = ST_SUM2;
            end
            ST_SUM2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // configuration, controller state, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= 31'd117965;
            r_ki        <= 31'd72090;
            r_kd        <= 31'd4915;
            r_target    <= 32'sd0;
            r_out_low   <= -32'sd6553600;
            r_out_high  <= 32'sd6553600;
            r_step_time <= 31'd6554;
            r_integral  <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KP:        r_kp        <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI:        r_ki        <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD:        r_kd        <= i_cfg_data[GAIN_W-1:0];
                    CFG_TARGET:    r_target    <= i_cfg_data;
                    CFG_OUT_LOW:   r_out_low   <= i_cfg_data;
                    CFG_OUT_HIGH:  r_out_high  <= i_cfg_data;
                    CFG_STEP_TIME: r_step_time <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_in_acc && i_in_word.mode) begin
                r_integral <= '0;
                r_last_err <= '0;
            end else if (w_out_load) begin
                // anti-windup: integral only moves when the output is not pinned
                if (!w_lim) begin
                    r_integral <= r_inew;
                end
                r_last_err <= r_err;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= w_err_in;
        end
        if (r_state == ST_MUL1 && w_mul_done) begin
            r_t <= sat64(w_sh0);
            r_u <= sat64(w_sh1);
        end
        if (r_state == ST_MUL2 && w_mul_done) begin
            r_inc <= sat64(w_sh0);
            r_p   <= sat64(w_sh1);
        end
        if (r_state == ST_MUL2 && w_div_done) begin
            r_d <= w_d_sat;
        end
        if (r_state == ST_SUM1) begin
            r_inew <= sat34(sext34(r_integral) + sext34(r_inc));
        end
        if (r_state == ST_SUM2) begin
            r_sum <= sext34(r_p) + sext34(r_inew) + sext34(r_d);
        end
        if (w_out_load) begin
            r_out_word.drive    <= w_drive;
            r_out_word.at_limit <= w_lim;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: dv/pid_clamped_anti_windup_top_test.sv
// ============================================================================
// pid_clamped_anti_windup_top_test
// Self-checking bench for the clamped PID step. An in-bench fixed point
// model predicts drive and at_limit for every accepted update word. A
// monitor compares each output word with the oldest prediction. Directed
// cases cover reset values, gain and bound extremes, exact clamp hits,
// crossed bounds, zero sample period and the unused register index.
// Randomized register sets then run under four flow-control mixes.
// ============================================================================

module pid_clamped_anti_windup_top_test;

    import pcaw_pkg::*;

    localparam int FRAC           = 16;
    localparam int LATENCY        = FRAC + 70;
    localparam int SETTLE         = LATENCY + 20;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_GAP        = 40;
    localparam int SETS_PER_PHASE = 3;
    localparam int ITEMS_PER_SET  = 63;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // no register decodes to this index
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int SET_NOMINAL = 0;
    localparam int SET_TIGHT   = 1;
    localparam int SET_FULL    = 2;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_word               i_in_word   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_word              o_out_word;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data  = '0;

    // bench copy of the registers and the loop state
    logic [GAIN_W-1:0]        gain_p     = 31'd117965;
    logic [GAIN_W-1:0]        gain_i     = 31'd72090;
    logic [GAIN_W-1:0]        gain_d     = 31'd4915;
    logic [GAIN_W-1:0]        sample_dt  = 31'd6554;
    logic signed [DATA_W-1:0] setpoint   = 32'sd0;
    logic signed [DATA_W-1:0] clamp_low  = -32'sd6553600;
    logic signed [DATA_W-1:0] clamp_high = 32'sd6553600;
    logic signed [DATA_W-1:0] integ_acc  = '0;
    logic signed [DATA_W-1:0] prev_err   = '0;

    t_out_word pending_drive[$];
    t_out_word want;

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_cnt     = 0;
    int n_fail        = 0;
    int n_update      = 0;
    int n_clear       = 0;
    int n_writes      = 0;
    int n_results     = 0;
    int n_at_limit    = 0;

    pid_clamped_anti_windup_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // one controller update; advances the integral and the stored error
    function automatic t_out_word predict_drive(input logic signed [DATA_W-1:0] meas);
        longint    err, p, t, inc, inew, diff, u, d, sum, dt, drv;
        t_out_word res;
        dt   = (sample_dt == '0) ? 64'sd1 : longint'(sample_dt);
        err  = clip32(longint'(setpoint) - longint'(meas));
        p    = clip32((longint'(gain_p) * err) >>> FRAC);
        t    = clip32((longint'(gain_i) * err) >>> FRAC);
        inc  = clip32((t * dt) >>> FRAC);
        inew = clip32(longint'(integ_acc) + inc);
        diff = clip32(err - longint'(prev_err));
        u    = clip32((longint'(gain_d) * diff) >>> FRAC);
        // SV division truncates toward zero
        d    = clip32((u * (64'sd1 <<< FRAC)) / dt);
        sum  = p + inew + d;
        // with crossed bounds the high bound wins only above it, else the low one
        if (sum > longint'(clamp_high)) begin
            drv = clamp_high;
        end else if (sum < longint'(clamp_low)) begin
            drv = clamp_low;
        end else begin
            drv = sum;
        end
        res.drive    = drv[DATA_W-1:0];
        res.at_limit = (drv == longint'(clamp_high)) || (drv == longint'(clamp_low));
        if (!res.at_limit) begin
            integ_acc = inew[DATA_W-1:0];
        end
        prev_err = err[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_drive.size() == 0) begin
                $error("output word with nothing pending: drive %0d at_limit %0b",
                       o_out_word.drive, o_out_word.at_limit);
                n_fail++;
            end else begin
                want = pending_drive.pop_front();
                if (o_out_word.drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, o_out_word.drive);
                    n_fail++;
                end
                if (o_out_word.at_limit !== want.at_limit) begin
                    $error("at_limit: expected %0b, got %0b",
                           want.at_limit, o_out_word.at_limit);
                    n_fail++;
                end
                n_results++;
                if (want.at_limit) begin
                    n_at_limit++;
                end
            end
        end
    end

    task automatic send_item(input logic is_clear, input logic [DATA_W-1:0] meas);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= t_in_word'{is_clear, meas};
        do @(posedge i_clk); while (!o_in_ready);
        if (is_clear == MODE_CLEAR) begin
            integ_acc = '0;
            prev_err  = '0;
            n_clear++;
        end else begin
            pending_drive.push_back(predict_drive(meas));
            n_update++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KP:        gain_p     = data[GAIN_W-1:0];
            CFG_KI:        gain_i     = data[GAIN_W-1:0];
            CFG_KD:        gain_d     = data[GAIN_W-1:0];
            CFG_TARGET:    setpoint   = data;
            CFG_OUT_LOW:   clamp_low  = data;
            CFG_OUT_HIGH:  clamp_high = data;
            CFG_STEP_TIME: sample_dt  = data[GAIN_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    // drop valid, let every result drain, then cover a possible clear in flight
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_item(MODE_UPDATE, 32'h0000_0000);
        send_item(MODE_UPDATE, 32'h0001_0000);
        send_item(MODE_UPDATE, 32'hFFFF_0000);
        send_item(MODE_UPDATE, S32_MAX);
        send_item(MODE_UPDATE, S32_MIN);
        send_item(MODE_CLEAR, 32'h1234_5678);
        send_item(MODE_UPDATE, 32'hFFFD_8000);
    endtask

    task automatic test_gain_extremes();
        wait_quiet();
        // bit 31 of a gain write must be dropped
        write_reg(CFG_KP, 32'hFFFF_FFFF);
        write_reg(CFG_KI, 32'hFFFF_FFFF);
        write_reg(CFG_KD, 32'hFFFF_FFFF);
        write_reg(CFG_TARGET, S32_MAX);
        write_reg(CFG_OUT_LOW, S32_MIN);
        write_reg(CFG_OUT_HIGH, S32_MAX);
        write_reg(CFG_STEP_TIME, 32'h0000_0001);
        send_item(MODE_UPDATE, S32_MIN);
        send_item(MODE_UPDATE, S32_MAX);
        send_item(MODE_UPDATE, 32'h0000_0000);
        wait_quiet();
        write_reg(CFG_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_TARGET, S32_MIN);
        send_item(MODE_UPDATE, S32_MAX);
        send_item(MODE_UPDATE, S32_MIN);
        wait_quiet();
        write_reg(CFG_KP, '0);
        write_reg(CFG_KI, '0);
        write_reg(CFG_KD, '0);
        send_item(MODE_UPDATE, $urandom());
    endtask

    // pure P path with unit gain, so the sum lands on a bound exactly
    task automatic test_exact_bound();
        wait_quiet();
        write_reg(CFG_KP, 32'h0001_0000);
        write_reg(CFG_KI, '0);
        write_reg(CFG_KD, '0);
        write_reg(CFG_TARGET, '0);
        write_reg(CFG_OUT_LOW, 32'hFFFD_0000);
        write_reg(CFG_OUT_HIGH, 32'h0005_0000);
        write_reg(CFG_STEP_TIME, 32'h0001_0000);
        send_item(MODE_CLEAR, '0);
        send_item(MODE_UPDATE, 32'hFFFB_0000);
        send_item(MODE_UPDATE, 32'h0003_0000);
        send_item(MODE_UPDATE, 32'hFFFC_0000);
    endtask

    task automatic test_crossed_bounds();
        wait_quiet();
        write_reg(CFG_OUT_LOW, 32'h000A_0000);
        write_reg(CFG_OUT_HIGH, 32'hFFF6_0000);
        send_item(MODE_UPDATE, 32'h0000_0000);
        send_item(MODE_UPDATE, 32'h000A_0000);
        send_item(MODE_UPDATE, 32'hFFEC_0000);
    endtask

    task automatic test_zero_step_time();
        wait_quiet();
        write_reg(CFG_STEP_TIME, '0);
        write_reg(CFG_KP, '0);
        write_reg(CFG_KI, 32'h0001_0000);
        write_reg(CFG_KD, 32'h0001_0000);
        write_reg(CFG_OUT_LOW, S32_MIN);
        write_reg(CFG_OUT_HIGH, S32_MAX);
        send_item(MODE_UPDATE, 32'hFFFF_0000);
        send_item(MODE_CLEAR, $urandom());
        send_item(MODE_UPDATE, 32'h0001_0000);
    endtask

    task automatic test_spare_index();
        wait_quiet();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_item(MODE_UPDATE, 32'h0002_0000);
    endtask

    task automatic test_random_phase(input int send_pct, input int stall_pct);
        logic [DATA_W-1:0] meas;
        int                span;
        int                pick;
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        for (int s = 0; s < SETS_PER_PHASE; s++) begin
            wait_quiet();
            if (s == SET_FULL) begin
                write_reg(CFG_KP, $urandom());
                write_reg(CFG_KI, $urandom());
                write_reg(CFG_KD, $urandom());
                write_reg(CFG_TARGET, $urandom());
                write_reg(CFG_OUT_LOW, $urandom());
                write_reg(CFG_OUT_HIGH, $urandom());
                write_reg(CFG_STEP_TIME, $urandom());
                write_reg(CFG_SPARE, $urandom());
            end else begin
                // tight set keeps the output pinned at the bounds most of the time
                span = (s == SET_NOMINAL) ? 200 : 4;
                write_reg(CFG_KP, $urandom_range(0, ((s == SET_TIGHT) ? 16 : 4) << 16));
                write_reg(CFG_KI, $urandom_range(0, 4 << 16));
                write_reg(CFG_KD, $urandom_range(0, 1 << 16));
                write_reg(CFG_TARGET, $urandom_range(0, span << 17) - (span << 16));
                write_reg(CFG_OUT_LOW, 32'd0 - ($urandom_range(1, span) << 16));
                write_reg(CFG_OUT_HIGH, $urandom_range(1, span) << 16);
                write_reg(CFG_STEP_TIME, $urandom_range(1, 1 << 16));
            end
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_item(MODE_CLEAR, $urandom());
                end else begin
                    if (pick == 1) begin
                        meas = S32_MIN;
                    end else if (pick == 2) begin
                        meas = S32_MAX;
                    end else if (pick <= 4) begin
                        meas = $urandom();
                    end else begin
                        meas = setpoint + ($urandom_range(0, 64 << 16) - (32 << 16));
                    end
                    send_item(MODE_UPDATE, meas);
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_gain_extremes();
        test_exact_bound();
        test_crossed_bounds();
        test_zero_step_time();
        test_spare_index();

        test_random_phase(0, 0);
        test_random_phase(81, 0);
        test_random_phase(0, 81);
        test_random_phase(20, 20);

        wait_quiet();
        if (pending_drive.size() != 0) begin
            $error("%0d predicted output words never arrived", pending_drive.size());
            n_fail++;
        end

        $display("Sent %0d update and %0d clear words after %0d register writes,",
                 n_update, n_clear, n_writes);
        $display("under four handshake mixes; %0d output words checked, %0d at a bound.",
                 n_results, n_at_limit);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
